FILE: hw/rtl/ansi_csi_escape_parser_top_macros.svh
// ----------------------------------------------------------------------------
// ansi csi escape parser assertion macros
// concurrent check wrappers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ANSI_CSI_ESCAPE_PARSER_TOP_MACROS_SVH
`define ANSI_CSI_ESCAPE_PARSER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define ACEP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acep assertion failed");
// next-cycle implication
`define ACEP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acep assertion failed");
`else
`define ACEP_ASSERT_IMP(lbl, ante, cons)
`define ACEP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: hw/rtl/acep_pkg.sv
// ----------------------------------------------------------------------------
// acep_pkg
// shared types and character codes of the csi escape parser
// ----------------------------------------------------------------------------
package acep_pkg;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESC    = 3'b010,
		MODE_CSI    = 3'b100
	} mode_t;

	typedef enum logic [4:0] {
		CMD_PRINT       = 5'd0,
		CMD_RESET       = 5'd1,
		CMD_SET_CURSOR  = 5'd2,
		CMD_UP          = 5'd3,
		CMD_DOWN        = 5'd4,
		CMD_RIGHT       = 5'd5,
		CMD_LEFT        = 5'd6,
		CMD_ERASE_S_END = 5'd7,
		CMD_ERASE_S_BEG = 5'd8,
		CMD_ERASE_S_ALL = 5'd9,
		CMD_ERASE_L_END = 5'd10,
		CMD_ERASE_L_BEG = 5'd11,
		CMD_ERASE_L_ALL = 5'd12,
		CMD_SCROLL      = 5'd13,
		CMD_ECHO        = 5'd14,
		CMD_INSERT      = 5'd15,
		CMD_DEMO_ENTER  = 5'd16,
		CMD_DEMO_EXIT   = 5'd17
	} cmd_t;

	typedef struct packed {
		logic       valid;
		cmd_t       cmd;
		logic [7:0] arg_a;
		logic [7:0] arg_b;
		logic       flag;
	} res_t;

	localparam logic [7:0] CH_ESC   = 8'h1B;
	localparam logic [7:0] CH_LBRKT = 8'h5B;
	localparam logic [7:0] CH_LOW_C = 8'h63;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QMARK = 8'h3F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_UP_C  = 8'h43;
	localparam logic [7:0] CH_UP_D  = 8'h44;
	localparam logic [7:0] CH_UP_H  = 8'h48;
	localparam logic [7:0] CH_UP_J  = 8'h4A;
	localparam logic [7:0] CH_UP_K  = 8'h4B;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LOW_A = 8'h61;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_H = 8'h68;
	localparam logic [7:0] CH_LOW_L = 8'h6C;
	localparam logic [7:0] CH_LOW_Z = 8'h7A;

	localparam logic [15:0] VAL_INSERT = 16'd4;
	localparam logic [15:0] VAL_ECHO   = 16'd100;
	localparam logic [15:0] VAL_DEMO   = 16'd101;

endpackage

FILE: hw/rtl/acep_parser.sv
// ----------------------------------------------------------------------------
// acep_parser
// parse state registers and single-byte step logic
// ----------------------------------------------------------------------------
`include "ansi_csi_escape_parser_top_macros.svh"

module acep_parser #(
	parameter int PARAM_CHAR_LIMIT = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte,
	input  logic            demo_active,
	output acep_pkg::res_t  res
);

	localparam int CW = $clog2(PARAM_CHAR_LIMIT + 1);
	localparam logic [CW-1:0] LIMIT = CW'(PARAM_CHAR_LIMIT);

	acep_pkg::mode_t mode_q, mode_d;
	logic [CW-1:0]   chars_q, chars_d;
	logic [1:0]      field_q, field_d;
	logic [15:0]     v0_q, v0_d;
	logic [15:0]     v1_q, v1_d;
	logic            p0_q, p0_d;
	logic            p1_q, p1_d;
	logic            priv_q, priv_d;

	logic            any;
	logic            v0_pos;
	logic            v1_pos;
	logic [7:0]      cnt;
	logic [15:0]     digit;
	logic [15:0]     v0_acc;
	logic [15:0]     v1_acc;
	logic [15:0]     v0_m1;
	logic [15:0]     v1_m1;
	logic            enable;
	acep_pkg::res_t  ex;

	assign any    = p0_q | p1_q;
	assign v0_pos = (v0_q != 16'd0) && !v0_q[15];
	assign v1_pos = (v1_q != 16'd0) && !v1_q[15];
	assign cnt    = (any && v0_pos) ? v0_q[7:0] : 8'd1;
	assign digit  = {12'd0, rx_byte[3:0]};
	assign v0_acc = (v0_q << 3) + (v0_q << 1) + digit;
	assign v1_acc = (v1_q << 3) + (v1_q << 1) + digit;
	assign v0_m1  = v0_q - 16'd1;
	assign v1_m1  = v1_q - 16'd1;
	assign enable = (rx_byte == acep_pkg::CH_LOW_H);

	// final letter decode
	always_comb begin
		ex = '0;
		ex.cmd = acep_pkg::CMD_PRINT;
		case (rx_byte)
			acep_pkg::CH_UP_H, acep_pkg::CH_LOW_F: begin
				ex.valid = 1'b1;
				ex.cmd   = acep_pkg::CMD_SET_CURSOR;
				if (p1_q) begin
					ex.arg_a = v1_pos ? v1_m1[7:0] : 8'd0;
					ex.arg_b = v0_pos ? v0_m1[7:0] : 8'd0;
				end
			end
			acep_pkg::CH_UP_A: begin
				ex.valid = 1'b1;
				ex.cmd   = acep_pkg::CMD_UP;
				ex.arg_a = cnt;
			end
			acep_pkg::CH_UP_B: begin
				ex.valid = 1'b1;
				ex.cmd   = acep_pkg::CMD_DOWN;
				ex.arg_a = cnt;
			end
			acep_pkg::CH_UP_C: begin
				ex.valid = 1'b1;
				ex.cmd   = acep_pkg::CMD_RIGHT;
				ex.arg_a = cnt;
			end
			acep_pkg::CH_UP_D: begin
				ex.valid = 1'b1;
				ex.cmd   = acep_pkg::CMD_LEFT;
				ex.arg_a = cnt;
			end
			acep_pkg::CH_UP_J, acep_pkg::CH_UP_K: begin
				if (!priv_q) begin
					if (v0_q == 16'd0 || !any) begin
						ex.valid = 1'b1;
						ex.cmd   = (rx_byte == acep_pkg::CH_UP_J) ?
							acep_pkg::CMD_ERASE_S_END : acep_pkg::CMD_ERASE_L_END;
					end else if (v0_q == 16'd1) begin
						ex.valid = 1'b1;
						ex.cmd   = (rx_byte == acep_pkg::CH_UP_J) ?
							acep_pkg::CMD_ERASE_S_BEG : acep_pkg::CMD_ERASE_L_BEG;
					end else if (v0_q == 16'd2) begin
						ex.valid = 1'b1;
						ex.cmd   = (rx_byte == acep_pkg::CH_UP_J) ?
							acep_pkg::CMD_ERASE_S_ALL : acep_pkg::CMD_ERASE_L_ALL;
					end
				end
			end
			acep_pkg::CH_LOW_H, acep_pkg::CH_LOW_L: begin
				if (priv_q) begin
					if (v0_q == acep_pkg::VAL_INSERT) begin
						ex.valid = 1'b1;
						ex.cmd   = acep_pkg::CMD_SCROLL;
						ex.flag  = enable;
					end else if (v0_q == acep_pkg::VAL_ECHO) begin
						ex.valid = 1'b1;
						ex.cmd   = acep_pkg::CMD_ECHO;
						ex.flag  = enable;
					end else if (v0_q == acep_pkg::VAL_DEMO) begin
						if (enable && !demo_active) begin
							ex.valid = 1'b1;
							ex.cmd   = acep_pkg::CMD_DEMO_ENTER;
						end else if (!enable && demo_active) begin
							ex.valid = 1'b1;
							ex.cmd   = acep_pkg::CMD_DEMO_EXIT;
						end
					end
				end else if (v0_q == acep_pkg::VAL_INSERT) begin
					ex.valid = 1'b1;
					ex.cmd   = acep_pkg::CMD_INSERT;
					ex.flag  = enable;
				end
			end
			default: begin
				ex.valid = 1'b0;
			end
		endcase
	end

	// byte step
	always_comb begin
		mode_d  = mode_q;
		chars_d = chars_q;
		field_d = field_q;
		v0_d    = v0_q;
		v1_d    = v1_q;
		p0_d    = p0_q;
		p1_d    = p1_q;
		priv_d  = priv_q;
		res     = '0;
		res.cmd = acep_pkg::CMD_PRINT;
		case (mode_q)
			acep_pkg::MODE_NORMAL: begin
				if (rx_byte == acep_pkg::CH_ESC) begin
					mode_d = acep_pkg::MODE_ESC;
				end else begin
					res.valid = 1'b1;
					res.arg_a = rx_byte;
				end
			end
			acep_pkg::MODE_ESC: begin
				if (rx_byte == acep_pkg::CH_LBRKT) begin
					mode_d  = acep_pkg::MODE_CSI;
					chars_d = '0;
					field_d = 2'd0;
					v0_d    = 16'd0;
					v1_d    = 16'd0;
					p0_d    = 1'b0;
					p1_d    = 1'b0;
					priv_d  = 1'b0;
				end else begin
					mode_d    = acep_pkg::MODE_NORMAL;
					res.valid = 1'b1;
					if (rx_byte == acep_pkg::CH_LOW_C) begin
						res.cmd = acep_pkg::CMD_RESET;
					end else begin
						res.arg_a = rx_byte;
					end
				end
			end
			acep_pkg::MODE_CSI: begin
				if (rx_byte inside {[acep_pkg::CH_0:acep_pkg::CH_9], acep_pkg::CH_SEMI}) begin
					if (chars_q < LIMIT) begin
						chars_d = chars_q + CW'(1);
						if (rx_byte == acep_pkg::CH_SEMI) begin
							if (field_q != 2'd2) begin
								field_d = field_q + 2'd1;
							end
						end else if (field_q == 2'd0) begin
							v0_d = v0_acc;
							p0_d = 1'b1;
						end else if (field_q == 2'd1) begin
							v1_d = v1_acc;
							p1_d = 1'b1;
						end
					end
				end else if (rx_byte == acep_pkg::CH_QMARK) begin
					priv_d = 1'b1;
				end else begin
					mode_d = acep_pkg::MODE_NORMAL;
					if (rx_byte inside {[acep_pkg::CH_UP_A:acep_pkg::CH_UP_Z],
						[acep_pkg::CH_LOW_A:acep_pkg::CH_LOW_Z]}) begin
						res = ex;
					end
				end
			end
			default: begin
				mode_d = acep_pkg::MODE_NORMAL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= acep_pkg::MODE_NORMAL;
			chars_q <= '0;
			field_q <= 2'd0;
			v0_q    <= 16'd0;
			v1_q    <= 16'd0;
			p0_q    <= 1'b0;
			p1_q    <= 1'b0;
			priv_q  <= 1'b0;
		end else if (step) begin
			mode_q  <= mode_d;
			chars_q <= chars_d;
			field_q <= field_d;
			v0_q    <= v0_d;
			v1_q    <= v1_d;
			p0_q    <= p0_d;
			p1_q    <= p1_d;
			priv_q  <= priv_d;
		end
	end

	`ACEP_ASSERT_IMP(a_chars_limit, 1'b1, chars_q <= LIMIT)
	`ACEP_ASSERT_IMP(a_field_range, 1'b1, field_q != 2'd3)
	`ACEP_ASSERT_NXT(a_csi_entry, step && mode_q == acep_pkg::MODE_ESC && rx_byte == acep_pkg::CH_LBRKT, chars_q == '0 && !p0_q && !p1_q && !priv_q)

endmodule

FILE: hw/rtl/ansi_csi_escape_parser_top.sv
// an accepted byte waits in the input register, then its command is registered
// throughput: one byte per cycle, stalls only when out_ready holds a waiting command
// the input register feeds the parser step and the command register when out_free
// reset: arst_n clears the parser to normal text mode and empties both registers
// ----------------------------------------------------------------------------
// ansi_csi_escape_parser_top
// terminal byte stream to command decoder with input and result registers
// ----------------------------------------------------------------------------
`include "ansi_csi_escape_parser_top_macros.svh"

module ansi_csi_escape_parser_top #(
	parameter int PARAM_CHAR_LIMIT = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       demo_active,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [4:0] command,
	output logic [7:0] arg_a,
	output logic [7:0] arg_b,
	output logic       mode_flag
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           demo_s1;
	logic           out_free;
	logic           adv;
	acep_pkg::res_t res;
	acep_pkg::res_t out_q;

	assign out_free = !out_q.valid || out_ready;
	assign adv      = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
			demo_s1 <= demo_active;
		end
	end

	acep_parser #(
		.PARAM_CHAR_LIMIT(PARAM_CHAR_LIMIT)
	) u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (adv),
		.rx_byte    (byte_s1),
		.demo_active(demo_s1),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q <= '0;
		end else begin
			if (out_free) begin
				out_q.valid <= adv && res.valid;
			end
			if (adv && res.valid) begin
				out_q.cmd   <= res.cmd;
				out_q.arg_a <= res.arg_a;
				out_q.arg_b <= res.arg_b;
				out_q.flag  <= res.flag;
			end
		end
	end

	assign out_valid = out_q.valid;
	assign command   = out_q.cmd;
	assign arg_a     = out_q.arg_a;
	assign arg_b     = out_q.arg_b;
	assign mode_flag = out_q.flag;

	`ACEP_ASSERT_IMP(a_ready_when_free, out_ready || !out_valid, in_ready)
	`ACEP_ASSERT_IMP(a_cmd_range, out_valid, command <= 5'd17)
	`ACEP_ASSERT_IMP(a_row_only_cursor,
		out_valid && command != acep_pkg::CMD_SET_CURSOR, arg_b == 8'd0)
	`ACEP_ASSERT_IMP(a_flag_only_modes, out_valid && mode_flag,
		command == acep_pkg::CMD_SCROLL || command == acep_pkg::CMD_ECHO ||
		command == acep_pkg::CMD_INSERT)

endmodule
